@@ rtl/substring_match_locator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the substring match locator
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_MATCH_LOCATOR_MACROS_SVH
`define SUBSTRING_MATCH_LOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SML_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sml: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SML_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sml: next-cycle check failed");

`endif

@@ rtl/sml_pkg.sv @@
// ----------------------------------------------------------------------------
// sml_pkg
// Shared types and constants of the substring match locator.
// ----------------------------------------------------------------------------
package sml_pkg;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 2'd2;

    localparam int                  LENGTH_REG_BITS = 5;
    localparam logic [LENGTH_REG_BITS-1:0] LENGTH_RESET = 5'd1;

    // Pattern storage: two 64-bit registers, sixteen bytes
    localparam int PATTERN_BYTES = 16;
    localparam int PATTERN_BITS  = 2 * CFG_DATA_BITS;

    // Marker byte: dropped together with the byte after it
    localparam logic [7:0] SKIP_MARK = 8'hC3;

    localparam int          RESULT_BITS = 16;
    localparam logic [RESULT_BITS-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
    } in_word_t;

    typedef struct packed {
        logic [RESULT_BITS-1:0] start_position;
        logic [RESULT_BITS-1:0] end_position;
        logic [RESULT_BITS-1:0] occurrence_count;
    } out_word_t;

    // Input register stage toward the core
    typedef struct packed {
        logic     valid;
        in_word_t word;
    } stage_t;

endpackage

@@ rtl/sml_in_stage.sv @@
// ----------------------------------------------------------------------------
// sml_in_stage
// Input register: captures one text word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module sml_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  sml_pkg::in_word_t  text_word,
    input  logic               take,
    output sml_pkg::stage_t    stage
);

    logic              valid_reg;
    logic              valid_next;
    sml_pkg::in_word_t word_reg;

    // Accept when empty or when the held word leaves this cycle
    assign text_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (text_valid && text_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            word_reg <= text_word;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

endmodule

@@ rtl/sml_matcher.sv @@
// ----------------------------------------------------------------------------
// sml_matcher
// Parallel byte comparators: checks the current byte and the recent-byte
// window against the pattern aligned to its configured length.
// ----------------------------------------------------------------------------
module sml_matcher #(
    parameter int PATTERN_MAX = 16,
    parameter int LEN_BITS    = 5,
    parameter int WIN_DEPTH   = 15
)
(
    input  logic [7:0]                          cur_byte,
    input  logic [WIN_DEPTH-1:0][7:0]           window,
    input  logic [sml_pkg::PATTERN_BITS-1:0]    pattern,
    input  logic [LEN_BITS-1:0]                 pattern_len,
    input  logic [LEN_BITS-1:0]                 kept_count,
    output logic                                hit
);

    logic [PATTERN_MAX-1:0][7:0] pat;
    logic [PATTERN_MAX-1:0][7:0] cand;
    logic [PATTERN_MAX-1:0][7:0] aligned;
    logic [PATTERN_MAX-1:0]      eq;

    // Unpack pattern bytes; bytes past the register pair read as zero
    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_pat
        if (g < sml_pkg::PATTERN_BYTES)
        begin : g_real
            assign pat[g] = pattern[8*g +: 8];
        end
        else
        begin : g_zero
            assign pat[g] = 8'h00;
        end
    end

    // Candidate bytes: newest first
    always_comb
    begin
        cand[0] = cur_byte;
        for (int j = 1; j < PATTERN_MAX; j++)
        begin
            cand[j] = window[j-1];
        end
    end

    // Candidate j lines up with pattern byte (len - 1 - j)
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            aligned[j] = 8'h00;
            for (int i = 0; i < PATTERN_MAX - j; i++)
            begin
                if (pattern_len == LEN_BITS'(i + j + 1))
                begin
                    aligned[j] = aligned[j] | pat[i];
                end
            end
            eq[j] = (pattern_len <= LEN_BITS'(j)) || (cand[j] == aligned[j]);
        end
    end

    assign hit = (pattern_len != '0) && (kept_count >= pattern_len) && (&eq);

endmodule

@@ rtl/substring_match_locator.sv @@
// ----------------------------------------------------------------------------
// substring_match_locator
// Finds every occurrence, overlapping ones included, of a configured pattern
// in a byte stream; a 0xC3 byte and its follower are dropped.
// ----------------------------------------------------------------------------
// Path: an accepted text word is held in the input register, then a match
// from its compare is loaded into the result register, which presents it.
// Throughput: one text word per cycle; a match word held by the receiver
// stalls the input once the input register has also filled.
// Reset: asynchronous, active low; pattern length returns to 1, pattern
// bytes, window, position, count and skip flag to zero.
// ----------------------------------------------------------------------------
`include "substring_match_locator_macros.svh"

module substring_match_locator #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sml_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [sml_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 text_valid,
    output logic                                 text_ready,
    input  sml_pkg::in_word_t                    text_word,
    output logic                                 match_valid,
    input  logic                                 match_ready,
    output sml_pkg::out_word_t                   match_word
);

    localparam int LEN_BITS  = $clog2(PATTERN_MAX + 1);
    localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int LW        = (LEN_BITS > sml_pkg::LENGTH_REG_BITS) ?
                               LEN_BITS : sml_pkg::LENGTH_REG_BITS;

    // Configuration registers
    logic [sml_pkg::LENGTH_REG_BITS-1:0] cfg_len_reg;
    logic [sml_pkg::CFG_DATA_BITS-1:0]   cfg_low_reg;
    logic [sml_pkg::CFG_DATA_BITS-1:0]   cfg_high_reg;

    // Text state
    logic [WIN_DEPTH-1:0][7:0]   win_reg,   win_next,   win_base;
    logic [LEN_BITS-1:0]         kept_reg,  kept_next,  kept_base, kept_inc;
    logic [POSITION_BITS-1:0]    pos_reg,   pos_next,   pos_base,  pos_inc;
    logic [sml_pkg::RESULT_BITS-1:0] total_reg, total_next, total_base;
    logic                        skip_reg,  skip_next,  skip_base;

    // Result register
    logic                        match_valid_reg, match_valid_next;
    sml_pkg::out_word_t          match_word_reg,  match_word_next;

    sml_pkg::stage_t             stage;
    logic                        take;
    logic                        kept_path;
    logic                        cmp_hit;
    logic                        hit;
    logic [LW-1:0]               len_wide;
    logic [LEN_BITS-1:0]         len_eff;
    logic [POSITION_BITS-1:0]    start_pos;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg  <= sml_pkg::LENGTH_RESET;
            cfg_low_reg  <= '0;
            cfg_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sml_pkg::REG_PATTERN_LENGTH:
                    cfg_len_reg  <= cfg_data[sml_pkg::LENGTH_REG_BITS-1:0];
                sml_pkg::REG_PATTERN_LOW:
                    cfg_low_reg  <= cfg_data;
                sml_pkg::REG_PATTERN_HIGH:
                    cfg_high_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // Clamp the pattern length to PATTERN_MAX
    always_comb
    begin
        len_wide = LW'(cfg_len_reg);
        if (len_wide > LW'(PATTERN_MAX))
        begin
            len_eff = LEN_BITS'(PATTERN_MAX);
        end
        else
        begin
            len_eff = LEN_BITS'(len_wide);
        end
    end

    sml_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_word  (text_word),
        .take       (take),
        .stage      (stage)
    );

    // Advance the held word when the result register can take its outcome
    assign take = stage.valid && (!match_valid_reg || match_ready);

    sml_matcher #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_BITS    (LEN_BITS),
        .WIN_DEPTH   (WIN_DEPTH)
    ) u_matcher
    (
        .cur_byte    (stage.word.text_byte),
        .window      (win_base),
        .pattern     ({cfg_high_reg, cfg_low_reg}),
        .pattern_len (len_eff),
        .kept_count  (kept_inc),
        .hit         (cmp_hit)
    );

    // Next text state: clear on a new text, drop marker and follower
    always_comb
    begin
        if (stage.word.first_byte)
        begin
            win_base   = '0;
            kept_base  = '0;
            pos_base   = '0;
            total_base = '0;
            skip_base  = 1'b0;
        end
        else
        begin
            win_base   = win_reg;
            kept_base  = kept_reg;
            pos_base   = pos_reg;
            total_base = total_reg;
            skip_base  = skip_reg;
        end

        kept_inc = (kept_base < LEN_BITS'(PATTERN_MAX)) ? kept_base + 1'b1 : kept_base;
        pos_inc  = (&pos_base) ? pos_base : pos_base + 1'b1;

        kept_path = !skip_base && (stage.word.text_byte != sml_pkg::SKIP_MARK);
        skip_next = !skip_base && (stage.word.text_byte == sml_pkg::SKIP_MARK);

        win_next  = win_base;
        kept_next = kept_base;
        pos_next  = pos_base;
        if (kept_path)
        begin
            win_next[0] = stage.word.text_byte;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                win_next[i] = win_base[i-1];
            end
            kept_next = kept_inc;
            pos_next  = pos_inc;
        end

        hit        = kept_path && cmp_hit;
        total_next = total_base;
        if (hit && (total_base != sml_pkg::COUNT_MAX))
        begin
            total_next = total_base + 1'b1;
        end

        start_pos = pos_inc - POSITION_BITS'(len_eff) + 1'b1;

        match_word_next.start_position   = sml_pkg::RESULT_BITS'(start_pos);
        match_word_next.end_position     = sml_pkg::RESULT_BITS'(pos_inc);
        match_word_next.occurrence_count = total_next;

        // Drop a taken result, load a new one
        match_valid_next = match_valid_reg && !match_ready;
        if (take && hit)
        begin
            match_valid_next = 1'b1;
        end
    end

    // Hold text state between words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            kept_reg  <= '0;
            pos_reg   <= '0;
            total_reg <= '0;
            skip_reg  <= 1'b0;
        end
        else if (take)
        begin
            win_reg   <= win_next;
            kept_reg  <= kept_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            skip_reg  <= skip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_valid_reg <= 1'b0;
        end
        else
        begin
            match_valid_reg <= match_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && hit)
        begin
            match_word_reg <= match_word_next;
        end
    end

    assign match_valid = match_valid_reg;
    assign match_word  = match_word_reg;

    // A match found on a taken word is presented next cycle
    `SML_ASSERT_NEXT(a_hit_presents, clk, rst_n, take && hit, match_valid_reg)
    // Kept count never passes PATTERN_MAX
    `SML_ASSERT_NOW(a_kept_bound, clk, rst_n, 1'b1, kept_reg <= LEN_BITS'(PATTERN_MAX))
    // Every reported match has counted itself
    `SML_ASSERT_NOW(a_count_nonzero, clk, rst_n, match_valid_reg,
        match_word_reg.occurrence_count != '0)
    // The follower of a marker is always consumed
    `SML_ASSERT_NEXT(a_skip_clears, clk, rst_n,
        take && skip_reg && !stage.word.first_byte, !skip_reg)

endmodule
